FILE: rtl/debounced_midi_button_handler_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the debounced MIDI button handler
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_MIDI_BUTTON_HANDLER_CORE_ASSERT_SVH
`define DEBOUNCED_MIDI_BUTTON_HANDLER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DMBH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition must never hold
`define DMBH_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/dmbh_pkg.sv
// ----------------------------------------------------------------------------
// dmbh_pkg
// Types and constants shared by the debounced MIDI button handler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmbh_pkg;

  // fixed field widths
  localparam int BtnW     = 6;
  localparam int MidiW    = 7;
  localparam int VelW     = 7;
  localparam int HistW    = 7;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;

  // debounce history patterns that count as stable
  localparam logic [HistW-1:0] HistZeros = '0;
  localparam logic [HistW-1:0] HistOnes  = '1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegVelOn  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegVelOff = 2'd1;
  localparam logic [CfgIdxW-1:0] RegReport = 2'd2;

  // reset values of the configuration registers
  localparam logic [VelW-1:0] VelOnReset  = 7'd127;
  localparam logic [VelW-1:0] VelOffReset = 7'd0;

  typedef enum logic {
    OP_SCAN  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_PROGRAM  = 2'd2
  } kind_e;

  // input word
  typedef struct packed {
    logic             opcode;
    logic [BtnW-1:0]  button_index;
    logic             level;
    logic             entry_mode;
    logic             entry_pc_enable;
    logic [MidiW-1:0] entry_midi_number;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0]       message_kind;
    logic [MidiW-1:0] midi_number;
    logic [VelW-1:0]  velocity;
    logic [BtnW-1:0]  source_button;
    logic             report_component;
  } out_word_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e              op;
    logic [BtnW-1:0]  btn;
    logic             level;
    logic             mode;
    logic             pc_en;
    logic [MidiW-1:0] midi;
  } cmd_t;

  // per-button state record
  typedef struct packed {
    logic [HistW-1:0] hist;
    logic             pressed;
    logic             last;
    logic             mode;
    logic             pc_en;
    logic [MidiW-1:0] midi;
  } btn_state_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [VelW-1:0] vel_on;
    logic [VelW-1:0] vel_off;
    logic            report;
  } cfg_t;

  // queue status toward front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: rtl/debounced_midi_button_handler_core.sv
// Path: a word passes queue slot, state read, result register to out_valid_o.
// Throughput: one word per cycle while out_ready_i does not stall, set by the
// single read-modify-write port of the per-button state memory; a same-button
// word right behind is bypassed.
// Reset: asynchronous; per-button valid bits clear at once, no clearing pass.
// ----------------------------------------------------------------------------
// debounced_midi_button_handler_core
// Debounces scanned button levels and turns stable edges into MIDI events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module debounced_midi_button_handler_core
  import dmbh_pkg::*;
#(
  parameter int NUM_BUTTONS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o
);

  logic [VelW-1:0] vel_on_q, vel_off_q;
  logic            report_q;
  cfg_t            cfg;
  q_status_t       q_status;
  logic            push, pop;
  cmd_t            push_cmd, head_cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_on_q  <= VelOnReset;
      vel_off_q <= VelOffReset;
      report_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegVelOn:  vel_on_q  <= cfg_data_i[VelW-1:0];
        RegVelOff: vel_off_q <= cfg_data_i[VelW-1:0];
        RegReport: report_q  <= cfg_data_i[0];
        default: begin
          report_q <= report_q;
        end
      endcase
    end
  end

  assign cfg.vel_on  = vel_on_q;
  assign cfg.vel_off = vel_off_q;
  assign cfg.report  = report_q;

  // front end
  dmbh_front #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // command queue
  dmbh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .status_o    (q_status)
  );

  // back end
  dmbh_back #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_status_i  (q_status),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // checks
  `include "debounced_midi_button_handler_core_assert.svh"

  `DMBH_ASSERT_NEVER(a_q_full_empty, q_status.full && q_status.empty, "queue full and empty")
  `DMBH_ASSERT_IMP(a_q_full_stalls, q_status.full, !in_ready_o && !push, "push into full queue")
  `DMBH_ASSERT_IMP(a_pc_vel_zero, out_valid_o && out_word_o.message_kind == KIND_PROGRAM, out_word_o.velocity == '0, "program change with velocity")

endmodule

FILE: rtl/dmbh_front.sv
// ----------------------------------------------------------------------------
// dmbh_front
// Accepts input words, drops out-of-range buttons and forms commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmbh_front
  import dmbh_pkg::*;
#(
  parameter int NUM_BUTTONS = 64
) (
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  input  q_status_t q_status_i,
  output logic      push_o,
  output cmd_t      cmd_o
);

  localparam logic [BtnW+1:0] NumLimit = (BtnW+2)'(NUM_BUTTONS);

  logic in_range;

  // range check on the button number
  assign in_range   = {2'b00, in_word_i.button_index} < NumLimit;
  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full && in_range;

  // command fields
  assign cmd_o.op    = op_e'(in_word_i.opcode);
  assign cmd_o.btn   = in_word_i.button_index;
  assign cmd_o.level = in_word_i.level;
  assign cmd_o.mode  = in_word_i.entry_mode;
  assign cmd_o.pc_en = in_word_i.entry_pc_enable;
  assign cmd_o.midi  = in_word_i.entry_midi_number;

endmodule

FILE: rtl/dmbh_queue.sv
// ----------------------------------------------------------------------------
// dmbh_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmbh_queue
  import dmbh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      push_data_i,
  input  logic      pop_i,
  output cmd_t      head_o,
  output q_status_t status_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o         = slot_q[rd_ptr_q];
  assign status_o.full  = count_q == 2'd2;
  assign status_o.empty = count_q == 2'd0;

endmodule

FILE: rtl/dmbh_back.sv
// ----------------------------------------------------------------------------
// dmbh_back
// Per-button state memory, debounce and event logic, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmbh_back
  import dmbh_pkg::*;
#(
  parameter int NUM_BUTTONS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  q_status_t q_status_i,
  input  cmd_t      head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  btn_state_t             mem_q [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] vld_q;

  logic       s2_valid_q;
  cmd_t       s2_cmd_q;
  btn_state_t rdata_q;
  logic       rvld_q;
  btn_state_t byp_q;
  logic       byp_hit_q;

  logic       out_valid_q;
  out_word_t  out_q;

  logic [BtnW+1:0]  head_wide, s2_wide;
  logic [IdxW-1:0]  head_addr, s2_addr;
  logic             s2_go;
  btn_state_t       cur, nxt;
  logic [HistW-1:0] hist_n;
  logic             emit;
  kind_e            kind;
  logic [VelW-1:0]  vel;

  // addresses
  assign head_wide = {2'b00, head_i.btn};
  assign s2_wide   = {2'b00, s2_cmd_q.btn};
  assign head_addr = head_wide[IdxW-1:0];
  assign s2_addr   = s2_wide[IdxW-1:0];

  // stage handshake: a stage moves when the result register can take it
  assign s2_go = s2_valid_q && (!out_valid_q || out_ready_i);
  assign pop_o = !q_status_i.empty && (!s2_valid_q || s2_go);

  // current record: bypass from the word just retired, else memory or reset value
  always_comb begin
    if (byp_hit_q) begin
      cur = byp_q;
    end else if (rvld_q) begin
      cur = rdata_q;
    end else begin
      cur = '0;
    end
  end

  // debounce and event decision
  always_comb begin
    nxt    = cur;
    emit   = 1'b0;
    kind   = KIND_NOTE_ON;
    vel    = '0;
    hist_n = {cur.hist[HistW-2:0], s2_cmd_q.level};
    unique case (s2_cmd_q.op)
      OP_WRITE: begin
        nxt.mode  = s2_cmd_q.mode;
        nxt.pc_en = s2_cmd_q.pc_en;
        nxt.midi  = s2_cmd_q.midi;
      end
      OP_SCAN: begin
        nxt.hist = hist_n;
        if (hist_n == HistZeros || hist_n == HistOnes) begin
          nxt.last = s2_cmd_q.level;
          if (cur.pc_en) begin
            // program change once per press
            if (s2_cmd_q.level) begin
              if (!cur.pressed) begin
                nxt.pressed = 1'b1;
                emit        = 1'b1;
                kind        = KIND_PROGRAM;
              end
            end else begin
              nxt.pressed = 1'b0;
            end
          end else if (cur.mode) begin
            // latching: toggle on a stable rising edge
            if (s2_cmd_q.level && !cur.last) begin
              emit        = 1'b1;
              nxt.pressed = !cur.pressed;
              if (cur.pressed) begin
                kind = KIND_NOTE_OFF;
                vel  = cfg_i.vel_off;
              end else begin
                kind = KIND_NOTE_ON;
                vel  = cfg_i.vel_on;
              end
            end
          end else begin
            // momentary
            if (s2_cmd_q.level) begin
              if (!cur.pressed) begin
                nxt.pressed = 1'b1;
                emit        = 1'b1;
                kind        = KIND_NOTE_ON;
                vel         = cfg_i.vel_on;
              end
            end else if (cur.pressed) begin
              nxt.pressed = 1'b0;
              emit        = 1'b1;
              kind        = KIND_NOTE_OFF;
              vel         = cfg_i.vel_off;
            end
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  // state memory: write on retire, registered read on pop
  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      mem_q[s2_addr] <= nxt;
    end
    if (pop_o) begin
      rdata_q <= mem_q[head_addr];
      s2_cmd_q <= head_i;
      byp_q    <= nxt;
    end
  end

  // valid bits stand in for the reset value of each record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rvld_q    <= 1'b0;
      byp_hit_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s2_go) begin
        vld_q[s2_addr] <= 1'b1;
      end
      if (pop_o) begin
        rvld_q    <= vld_q[head_addr];
        byp_hit_q <= s2_go && (s2_addr == head_addr);
        s2_valid_q <= 1'b1;
      end else if (s2_go) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_go && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && emit) begin
      out_q.message_kind     <= kind;
      out_q.midi_number      <= cur.midi;
      out_q.velocity         <= vel;
      out_q.source_button    <= s2_cmd_q.btn;
      out_q.report_component <= cfg_i.report;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: tb/sv/tb_debounced_midi_button_handler_core.sv
// ----------------------------------------------------------------------------
// tb_debounced_midi_button_handler_core
// Drives scan and table-write words into the button handler and checks every
// MIDI event word against an in-bench predictor of the per-button debounce and
// mode logic. A short directed table comes first, then random press/release
// runs over a few buttons mixed with table writes and noise, in several
// register settings. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_debounced_midi_button_handler_core
  import dmbh_pkg::*;
();

  localparam int NumButtons    = 64;
  localparam int InW           = $bits(in_word_t);
  localparam int PhaseWords    = 270;
  localparam int NumPhases     = 5;
  localparam int SettleCycles  = 8;
  localparam int WatchdogLimit = 2000;
  localparam int MaxPrinted    = 40;

  // how a directed row gets its expectation
  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_NONE  = 2'd1,
    CHK_WORD  = 2'd2
  } chk_e;

  typedef struct packed {
    in_word_t  word;
    chk_e      chk;
    out_word_t res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_word_t            in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_word_t           out_word;

  debounced_midi_button_handler_core #(
    .NUM_BUTTONS(NumButtons)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // predictor state: per-button records and register copies
  logic [HistW-1:0] hist_mem    [NumButtons];
  logic             pressed_mem [NumButtons];
  logic             last_mem    [NumButtons];
  logic             mode_mem    [NumButtons];
  logic             pc_mem      [NumButtons];
  logic [MidiW-1:0] number_mem  [NumButtons];
  logic [VelW-1:0]  vel_on_cfg  = VelOnReset;
  logic [VelW-1:0]  vel_off_cfg = VelOffReset;
  logic             report_cfg  = 1'b0;

  out_word_t pending_events[$];
  int        mismatch_cnt = 0;
  int        idle_pct = 7;
  int        stall_cycles = 0;

  // random press/release runs on a few buttons at once
  logic [BtnW-1:0] run_btn  [4];
  logic            run_lvl  [4];
  int              run_left [4];

  initial begin
    for (int i = 0; i < NumButtons; i++) begin
      hist_mem[i]    = HistZeros;
      pressed_mem[i] = 1'b0;
      last_mem[i]    = 1'b0;
      mode_mem[i]    = 1'b0;
      pc_mem[i]      = 1'b0;
      number_mem[i]  = '0;
    end
    for (int k = 0; k < 4; k++) begin
      run_btn[k]  = BtnW'($urandom);
      run_lvl[k]  = 1'b0;
      run_left[k] = 0;
    end
  end

  task automatic flag_mismatch(input string what);
    if (mismatch_cnt < MaxPrinted) $display("mismatch at %0t: %s", $time, what);
    mismatch_cnt++;
  endtask

  // next MIDI event of one word; updates the predictor state
  function automatic bit predict_midi_event(input in_word_t w, output out_word_t ev);
    logic [HistW-1:0] h;
    int               b;
    bit               fire;
    kind_e            kind;
    logic [VelW-1:0]  vel;
    b    = w.button_index;
    fire = 1'b0;
    kind = KIND_NOTE_ON;
    vel  = '0;
    ev   = '0;
    if (w.opcode == OP_WRITE) begin
      mode_mem[b]   = w.entry_mode;
      pc_mem[b]     = w.entry_pc_enable;
      number_mem[b] = w.entry_midi_number;
      return 1'b0;
    end
    h = {hist_mem[b][HistW-2:0], w.level};
    hist_mem[b] = h;
    if (h != HistZeros && h != HistOnes) return 1'b0;
    if (pc_mem[b]) begin
      // program change: once per press, mode ignored
      if (w.level) begin
        if (!pressed_mem[b]) begin
          pressed_mem[b] = 1'b1;
          fire = 1'b1;
          kind = KIND_PROGRAM;
        end
      end else begin
        pressed_mem[b] = 1'b0;
      end
    end else if (mode_mem[b]) begin
      // latching: toggle on a rising stable edge
      if (w.level && !last_mem[b]) begin
        fire = 1'b1;
        if (pressed_mem[b]) begin
          pressed_mem[b] = 1'b0;
          kind = KIND_NOTE_OFF;
          vel  = vel_off_cfg;
        end else begin
          pressed_mem[b] = 1'b1;
          vel  = vel_on_cfg;
        end
      end
    end else begin
      // momentary
      if (w.level) begin
        if (!pressed_mem[b]) begin
          pressed_mem[b] = 1'b1;
          fire = 1'b1;
          vel  = vel_on_cfg;
        end
      end else if (pressed_mem[b]) begin
        pressed_mem[b] = 1'b0;
        fire = 1'b1;
        kind = KIND_NOTE_OFF;
        vel  = vel_off_cfg;
      end
    end
    last_mem[b] = w.level;
    ev.message_kind     = kind;
    ev.midi_number      = number_mem[b];
    ev.velocity         = vel;
    ev.source_button    = w.button_index;
    ev.report_component = report_cfg;
    return fire;
  endfunction

  // random word: mostly clean runs, some table writes and noise
  function automatic in_word_t next_button_word();
    in_word_t w;
    int       r;
    int       k;
    w = in_word_t'(InW'($urandom));
    r = $urandom_range(99);
    k = $urandom_range(3);
    if (r < 8) begin
      w.opcode = OP_WRITE;
      if (r < 6) w.button_index = run_btn[k];
    end else if (r < 14) begin
      w.opcode = OP_SCAN;
    end else begin
      if (r < 16) run_btn[k] = BtnW'($urandom);
      if (run_left[k] == 0) begin
        run_lvl[k]  = !run_lvl[k];
        // short runs act as contact bounce
        run_left[k] = ($urandom_range(99) < 20) ? $urandom_range(1, 6)
                                                : $urandom_range(7, 12);
      end
      w.opcode       = OP_SCAN;
      w.button_index = run_btn[k];
      w.level        = run_lvl[k];
      run_left[k]--;
    end
    return w;
  endfunction

  // hand one word over; valid stays up across back-to-back words
  task automatic push_word(input in_word_t w, input chk_e chk, input out_word_t typed);
    out_word_t ev;
    bit        fire;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fire = predict_midi_event(w, ev);
    if (chk == CHK_NONE) begin
      fire = 1'b0;
    end else if (chk == CHK_WORD) begin
      fire = 1'b1;
      ev   = typed;
    end
    if (fire) pending_events.push_back(ev);
  endtask

  // block quiet: no words in flight, nothing owed
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_regs(input logic [VelW-1:0] von, input logic [VelW-1:0] voff,
                            input logic rep);
    cfg_we   <= 1'b1;
    cfg_idx  <= RegVelOn;
    cfg_data <= von;
    @(posedge clk);
    cfg_idx  <= RegVelOff;
    cfg_data <= voff;
    @(posedge clk);
    // upper data bits are don't care for the one-bit register
    cfg_idx  <= RegReport;
    cfg_data <= {6'($urandom), rep};
    @(posedge clk);
    cfg_we      <= 1'b0;
    vel_on_cfg  = von;
    vel_off_cfg = voff;
    report_cfg  = rep;
  endtask

  function automatic dir_row_t mk_row(input op_e op, input int btn, input bit lvl,
                                      input bit md, input bit pc, input int num,
                                      input chk_e chk, input out_word_t res);
    dir_row_t row;
    row.word                   = '0;
    row.word.opcode            = op;
    row.word.button_index      = BtnW'(btn);
    row.word.level             = lvl;
    row.word.entry_mode        = md;
    row.word.entry_pc_enable   = pc;
    row.word.entry_midi_number = MidiW'(num);
    row.chk                    = chk;
    row.res                    = res;
    return row;
  endfunction

  function automatic out_word_t mk_event(input kind_e kind, input int num, input int vel,
                                         input int btn);
    out_word_t ev;
    ev.message_kind     = kind;
    ev.midi_number      = MidiW'(num);
    ev.velocity         = VelW'(vel);
    ev.source_button    = BtnW'(btn);
    ev.report_component = 1'b0;
    return ev;
  endfunction

  // result side: random stalls and in-order compare
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected word from button %0d", out_word.source_button));
      end else begin
        want = pending_events.pop_front();
        if (out_word.message_kind !== want.message_kind)
          flag_mismatch($sformatf("button %0d kind %0d, want %0d", want.source_button,
                                  out_word.message_kind, want.message_kind));
        if (out_word.midi_number !== want.midi_number)
          flag_mismatch($sformatf("button %0d number %0d, want %0d", want.source_button,
                                  out_word.midi_number, want.midi_number));
        if (out_word.velocity !== want.velocity)
          flag_mismatch($sformatf("button %0d velocity %0d, want %0d", want.source_button,
                                  out_word.velocity, want.velocity));
        if (out_word.source_button !== want.source_button)
          flag_mismatch($sformatf("source button %0d, want %0d",
                                  out_word.source_button, want.source_button));
        if (out_word.report_component !== want.report_component)
          flag_mismatch($sformatf("button %0d report %0b, want %0b", want.source_button,
                                  out_word.report_component, want.report_component));
      end
    end
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("tb_debounced_midi_button_handler_core: errors");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // momentary press on button 0, stable hold, program change on button 63
    // with latching mode set (mode ignored), then release of button 0
    dir_rows.push_back(mk_row(OP_WRITE, 0, 1'b0, 1'b0, 1'b0, 127, CHK_NONE, '0));
    repeat (6) dir_rows.push_back(mk_row(OP_SCAN, 0, 1'b1, 1'b0, 1'b0, 0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row(OP_SCAN, 0, 1'b1, 1'b0, 1'b0, 0, CHK_WORD,
                              mk_event(KIND_NOTE_ON, 127, 127, 0)));
    dir_rows.push_back(mk_row(OP_SCAN, 0, 1'b1, 1'b1, 1'b1, 127, CHK_NONE, '0));
    dir_rows.push_back(mk_row(OP_WRITE, 63, 1'b1, 1'b1, 1'b1, 0, CHK_NONE, '0));
    repeat (6) dir_rows.push_back(mk_row(OP_SCAN, 63, 1'b1, 1'b0, 1'b0, 0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row(OP_SCAN, 63, 1'b1, 1'b0, 1'b0, 0, CHK_WORD,
                              mk_event(KIND_PROGRAM, 0, 0, 63)));
    repeat (6) dir_rows.push_back(mk_row(OP_SCAN, 0, 1'b0, 1'b0, 1'b0, 0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row(OP_SCAN, 0, 1'b0, 1'b0, 1'b0, 0, CHK_WORD,
                              mk_event(KIND_NOTE_OFF, 127, 0, 0)));
    @(posedge clk);
    foreach (dir_rows[i]) push_word(dir_rows[i].word, dir_rows[i].chk, dir_rows[i].res);

    // random phases, one register setting each; second phase never idles
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      case (ph)
        0:       write_regs(7'd0, 7'd127, 1'b1);
        1:       write_regs(7'd127, 7'd0, 1'b0);
        default: write_regs(VelW'($urandom), VelW'($urandom), 1'($urandom));
      endcase
      idle_pct = (ph == 1) ? 0 : 7;
      repeat (PhaseWords) push_word(next_button_word(), CHK_MODEL, '0);
    end

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("tb_debounced_midi_button_handler_core: clean");
    end else begin
      $display("tb_debounced_midi_button_handler_core: errors");
    end
    $finish;
  end

endmodule
